[rtl/bf_pkg.sv]
// Box filter package: widths, register indexes, controller states,
// controller/datapath command and status types, divisor reciprocal table.
// No dependencies.
`timescale 1ns / 1ps
package bf_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int SUM_W       = 12;  // 9 * 255 fits
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int NPAIR       = 4;

  localparam logic [CFG_W-1:0] FRAME_RESET = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_MUL,
    ST_OUT,
    ST_ADV
  } bf_state_t;

  typedef struct packed {
    logic       capture;  // take pixel
    logic       shift;    // window shift and line store write
    logic       sum;      // neighborhood sum for pair
    logic       mul;      // reciprocal multiply into output register
    logic       advance;  // step row/column position
    logic [1:0] pair;     // {row choice, column choice}
    logic       last;
  } bf_cmd_t;

  typedef struct packed {
    logic [NPAIR-1:0] pair_mask;
  } bf_status_t;

  // ceil(2^16 / n) for the divisors that can occur; exact for sums below 2^15
  function automatic logic [RECIP_W-1:0] recip(input logic [1:0] nr, input logic [1:0] nc);
    logic [3:0] n;
    n = 4'(nr) * 4'(nc);
    case (n)
      4'd1:    recip = 17'd65536;
      4'd2:    recip = 17'd32768;
      4'd3:    recip = 17'd21846;
      4'd4:    recip = 17'd16384;
      4'd6:    recip = 17'd10923;
      4'd9:    recip = 17'd7282;
      default: recip = '0;
    endcase
  endfunction

endpackage

[rtl/bf_in_if.sv]
// Pixel input channel: valid/ready handshake with one 8-bit pixel.
// Depends on bf_pkg.
`timescale 1ns / 1ps
interface bf_in_if;
  import bf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

[rtl/bf_out_if.sv]
// Result channel: valid/ready handshake with smoothed value, coordinates
// and the last-result flag. Depends on bf_pkg.
`timescale 1ns / 1ps
interface bf_out_if;
  import bf_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   smoothed;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               run_last;

  modport source (output valid, output smoothed, output out_row, output out_col,
                  output run_last, input ready);
  modport sink   (input valid, input smoothed, input out_row, input out_col,
                  input run_last, output ready);
endinterface

[rtl/bf_ctrl.sv]
// Box filter sequencer: steps each pixel through line store read, window
// shift, and one sum/multiply/transfer pass per completed centre.
// Depends on bf_pkg.
`timescale 1ns / 1ps
module bf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bf_pkg::bf_status_t status,
  output bf_pkg::bf_cmd_t    cmd
);
  import bf_pkg::*;

  bf_state_t  state_r, state_nxt;
  logic [1:0] pair_r, pair_nxt;

  // first set mask bit at or above start: {found, index}
  function automatic logic [2:0] find_pair(input logic [NPAIR-1:0] mask,
                                           input logic [2:0] start);
    logic       found;
    logic [1:0] idx;
    found = 1'b0;
    idx   = '0;
    for (int k = 0; k < NPAIR; k++) begin
      if (!found && 3'(k) >= start && mask[k]) begin
        found = 1'b1;
        idx   = 2'(k);
      end
    end
    find_pair = {found, idx};
  endfunction

  logic [2:0] first_hit, later_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pair_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pair_r  <= pair_nxt;
    end
  end

  always_comb begin
    first_hit = find_pair(status.pair_mask, 3'd0);
    later_hit = find_pair(status.pair_mask, 3'(pair_r) + 3'd1);

    state_nxt   = state_r;
    pair_nxt    = pair_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.pair    = pair_r;
    cmd.last    = ~later_hit[2];

    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (first_hit[2]) begin
          pair_nxt  = first_hit[1:0];
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (later_hit[2]) begin
            pair_nxt  = later_hit[1:0];
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/bf_datapath.sv]
// Box filter datapath: frame size registers, position counters, packed
// two-line store, 3x3 window, masked sum and reciprocal divide.
// Depends on bf_pkg.
`timescale 1ns / 1ps
module bf_datapath #(
  parameter int MAX_WIDTH  = bf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf_pkg::CFG_W-1:0]      cfg_data,
  input  logic [bf_pkg::PIX_W-1:0]      pixel,
  input  bf_pkg::bf_cmd_t               cmd,
  output bf_pkg::bf_status_t            status,
  output logic [bf_pkg::PIX_W-1:0]      smoothed,
  output logic [bf_pkg::COORD_W-1:0]    out_row,
  output logic [bf_pkg::COORD_W-1:0]    out_col,
  output logic                          run_last
);
  import bf_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WWF = $clog2(MAX_WIDTH + 1);
  localparam int HWF = $clog2(MAX_HEIGHT + 1);
  localparam int EW  = (WWF > CFG_W) ? WWF : CFG_W;
  localparam int EH  = (HWF > CFG_W) ? HWF : CFG_W;
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [CFG_W-1:0]     width_cfg_r, height_cfg_r;
  logic [CW-1:0]        col_r;
  logic [RW-1:0]        row_r;
  logic [PIX_W-1:0]     pixel_r;
  logic [PIX_W-1:0]     window_r [9];
  logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]   rd_r;     // {older, previous} at col_r
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [RECIP_W-1:0]   recip_r;
  logic [PROD_W-1:0]    prod;
  logic [PIX_W-1:0]     smoothed_r;
  logic [COORD_W-1:0]   out_row_r, out_col_r;
  logic                 run_last_r;

  logic [EW-1:0] w_ext, last_col_full;
  logic [EH-1:0] h_ext, last_row_full;
  logic          at_last_col, at_last_row, row_ge1, row_ge2, col_ge1, col_ge2;
  logic [2:0]    row_mask, col_mask;
  logic [RW-1:0] centre_row;
  logic [CW-1:0] centre_col;

  // effective frame size: zero acts as one, oversize saturates
  always_comb begin
    w_ext = EW'(width_cfg_r);
    h_ext = EH'(height_cfg_r);
    if (w_ext == '0)                     last_col_full = '0;
    else if (w_ext > EW'(MAX_WIDTH))     last_col_full = EW'(MAX_WIDTH - 1);
    else                                 last_col_full = w_ext - EW'(1);
    if (h_ext == '0)                     last_row_full = '0;
    else if (h_ext > EH'(MAX_HEIGHT))    last_row_full = EH'(MAX_HEIGHT - 1);
    else                                 last_row_full = h_ext - EH'(1);

    at_last_col = (EW'(col_r) == last_col_full);
    at_last_row = (EH'(row_r) == last_row_full);
    row_ge1     = |row_r;
    col_ge1     = |col_r;
    row_ge2     = ({2'b00, row_r} >= (RW + 2)'(2));
    col_ge2     = ({2'b00, col_r} >= (CW + 2)'(2));
  end

  // pair index {a,b}: a picks row r-1 or r, b picks column c-1 or c
  always_comb begin
    status.pair_mask[0] = row_ge1 & col_ge1;
    status.pair_mask[1] = row_ge1 & at_last_col;
    status.pair_mask[2] = at_last_row & col_ge1;
    status.pair_mask[3] = at_last_row & at_last_col;
  end

  // in-frame window rows/cols for the selected centre (bit 0 = oldest)
  always_comb begin
    row_mask   = cmd.pair[1] ? {1'b1, row_ge1, 1'b0} : {1'b1, 1'b1, row_ge2};
    col_mask   = cmd.pair[0] ? {1'b1, col_ge1, 1'b0} : {1'b1, 1'b1, col_ge2};
    centre_row = cmd.pair[1] ? row_r : row_r - RW'(1);
    centre_col = cmd.pair[0] ? col_r : col_r - CW'(1);
    sum_nxt    = '0;
    for (int rs = 0; rs < 3; rs++) begin
      for (int cs = 0; cs < 3; cs++) begin
        if (row_mask[rs] && col_mask[cs]) begin
          sum_nxt = sum_nxt + SUM_W'(window_r[rs*3 + cs]);
        end
      end
    end
  end

  assign prod = PROD_W'(sum_r) * PROD_W'(recip_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= FRAME_RESET;
      height_cfg_r <= FRAME_RESET;
      row_r        <= '0;
      col_r        <= '0;
      for (int k = 0; k < 9; k++) window_r[k] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH:  width_cfg_r  <= cfg_data;
          REG_FRAME_HEIGHT: height_cfg_r <= cfg_data;
          default: ;
        endcase
        row_r <= '0;
        col_r <= '0;
      end else if (cmd.advance) begin
        if (at_last_col) begin
          col_r <= '0;
          row_r <= at_last_row ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (cmd.shift) begin
        for (int rs = 0; rs < 3; rs++) begin
          window_r[rs*3]     <= window_r[rs*3 + 1];
          window_r[rs*3 + 1] <= window_r[rs*3 + 2];
        end
        window_r[2] <= rd_r[2*PIX_W-1:PIX_W];
        window_r[5] <= rd_r[PIX_W-1:0];
        window_r[8] <= pixel_r;
      end
    end
  end

  // line store: read every cycle at the current column, written on shift
  always_ff @(posedge clk) begin
    rd_r <= line_mem[col_r];
    if (cmd.shift) line_mem[col_r] <= {rd_r[PIX_W-1:0], pixel_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) pixel_r <= pixel;
    if (cmd.sum) begin
      sum_r     <= sum_nxt;
      recip_r   <= recip(2'($countones(row_mask)), 2'($countones(col_mask)));
      out_row_r <= COORD_W'(centre_row);
      out_col_r <= COORD_W'(centre_col);
    end
    if (cmd.mul) begin
      smoothed_r <= prod[RECIP_SHIFT +: PIX_W];
      run_last_r <= cmd.last;
    end
  end

  assign smoothed = smoothed_r;
  assign out_row  = out_row_r;
  assign out_col  = out_col_r;
  assign run_last = run_last_r;

endmodule

[rtl/box_filter_3x3_edge_average_top.sv]
// 3x3 box filter with border clipping, top level. Pixels arrive in raster
// order; each pixel is accepted, shifts the window and updates the line
// store, then takes a sum, a reciprocal multiply and an output transfer
// for each of the n (0 to 4) centres it completes, and finally advances
// the position; all results go through a single shared sum/multiply unit.
// Writing either frame size register restarts the frame at row 0, column 0.
// Depends on bf_pkg, bf_in_if, bf_out_if, bf_ctrl, bf_datapath.
`timescale 1ns / 1ps
module box_filter_3x3_edge_average_top #(
  parameter int MAX_WIDTH  = bf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bf_pkg::CFG_W-1:0]     cfg_data,
  bf_in_if.sink                        in_ch,
  bf_out_if.source                     out_ch
);
  import bf_pkg::*;

  bf_cmd_t    cmd;
  bf_status_t status;

  bf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (in_ch.pixel),
    .cmd       (cmd),
    .status    (status),
    .smoothed  (out_ch.smoothed),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .run_last  (out_ch.run_last)
  );

endmodule
